/* sv/u8d_pkg.sv */
package u8d_pkg;

    // Width of the character count carried in each result item.
    localparam int COUNT_W = 16;
    // Width of a decoded code point.
    localparam int CP_W = 21;

    // Register indexes on the configuration port.
    localparam logic REG_BYTE_LIMIT = 1'b0;
    localparam logic REG_CHAR_LIMIT = 1'b1;

    // Result status codes.
    localparam logic [1:0] ST_CHAR       = 2'd0;
    localparam logic [1:0] ST_NUL        = 2'd1;
    localparam logic [1:0] ST_ILLEGAL    = 2'd2;
    localparam logic [1:0] ST_INCOMPLETE = 2'd3;

    // A classified input byte as it travels from the front end to the back end.
    typedef struct packed {
        logic       start;
        logic       is_cont;
        logic       bad_lead;
        logic [2:0] seq_len;
        logic [6:0] lead_bits;
        logic [5:0] cont_bits;
    } item_t;

endpackage

/* sv/utf8_decode_stream.sv */
// Channel   Direction  Ports                 Contents
// s_        in         tvalid/tready/tdata   tdata[7:0] byte_value; tuser start_req
// m_        out        tvalid/tready/tdata   tdata[20:0] code_point, [36:21] char_count;
//                                            tuser[1:0] status; tlast done_res
// cfg_      in         wen/index/wdata       index 0 byte_limit, 1 char_limit
//
// One byte is accepted per cycle while the queue has room; the byte that completes a
// result waits in the queue, and the result is then held in the output register.
// The two-entry queue between the classifier and the decoder lets the input keep
// flowing while the output is stalled, until the queue is full.
// Reset (aresetn low at a clock edge) empties the queue and output, sets both
// limits to all ones (unlimited) and clears the decoder state.

module utf8_decode_stream #(
    parameter int LIMIT_BITS = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wen,
    input  logic                  cfg_index,
    input  logic [LIMIT_BITS-1:0] cfg_wdata,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,   // [7:0] byte_value
    input  logic                  s_tuser,   // [0] start_req
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [39:0]           m_tdata,   // [20:0] code_point, [36:21] char_count
    output logic [1:0]            m_tuser,   // [1:0] status
    output logic                  m_tlast
);

    u8d_pkg::item_t front_item;
    u8d_pkg::item_t q_item;
    logic           push;
    logic           pop;
    logic           q_not_full;
    logic           q_not_empty;

    u8d_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_ready  (q_not_full),
        .push     (push),
        .item     (front_item)
    );

    u8d_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (front_item),
        .not_full  (q_not_full),
        .pop       (pop),
        .pop_item  (q_item),
        .not_empty (q_not_empty)
    );

    u8d_back #(
        .LIMIT_BITS (LIMIT_BITS)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wen     (cfg_wen),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .q_not_empty (q_not_empty),
        .q_item      (q_item),
        .pop         (pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

endmodule

/* sv/u8d_front.sv */
module u8d_front (
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [7:0]       s_tdata,
    input  logic             s_tuser,
    input  logic             q_ready,
    output logic             push,
    output u8d_pkg::item_t   item
);

    always_comb begin
        item           = '0;
        item.start     = s_tuser;
        item.cont_bits = s_tdata[5:0];
        item.is_cont   = (s_tdata[7:6] == 2'b10);
        // The lead-byte class follows from the run of leading ones.
        unique casez (s_tdata)
            8'b0???_???? : begin
                item.seq_len   = 3'd1;
                item.lead_bits = s_tdata[6:0];
            end
            8'b110?_???? : begin
                item.seq_len   = 3'd2;
                item.lead_bits = {2'b00, s_tdata[4:0]};
            end
            8'b1110_???? : begin
                item.seq_len   = 3'd3;
                item.lead_bits = {3'b000, s_tdata[3:0]};
            end
            8'b1111_0??? : begin
                item.seq_len   = 3'd4;
                item.lead_bits = {4'b0000, s_tdata[2:0]};
            end
            default : begin
                item.bad_lead  = 1'b1;
            end
        endcase
    end

    assign s_tready = q_ready;
    assign push     = s_tvalid && q_ready;

endmodule

/* sv/u8d_queue.sv */
module u8d_queue (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  u8d_pkg::item_t   push_item,
    output logic             not_full,
    input  logic             pop,
    output u8d_pkg::item_t   pop_item,
    output logic             not_empty
);

    u8d_pkg::item_t mem [0:1];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

    assign pop_item  = mem[rd_ptr_reg];
    assign not_empty = (count_reg != 2'd0);
    assign not_full  = (count_reg != 2'd2);

endmodule

/* sv/u8d_back.sv */
module u8d_back #(
    parameter int LIMIT_BITS = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wen,
    input  logic                  cfg_index,
    input  logic [LIMIT_BITS-1:0] cfg_wdata,
    input  logic                  q_not_empty,
    input  u8d_pkg::item_t        q_item,
    output logic                  pop,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [39:0]           m_tdata,
    output logic [1:0]            m_tuser,
    output logic                  m_tlast
);

    localparam int CountW = u8d_pkg::COUNT_W;
    localparam int CpW    = u8d_pkg::CP_W;

    logic [LIMIT_BITS-1:0] byte_limit_reg;
    logic [LIMIT_BITS-1:0] char_limit_reg;
    logic [LIMIT_BITS-1:0] budget_reg, budget_next;
    logic [LIMIT_BITS-1:0] chars_reg, chars_next;
    logic [2:0]            bytes_left_reg, bytes_left_next;
    logic [CpW-1:0]        acc_reg, acc_next;
    logic                  stopped_reg, stopped_next;

    logic                  m_valid_reg, m_valid_next;
    logic [CpW-1:0]        m_cp_reg;
    logic [1:0]            m_status_reg;
    logic [CountW-1:0]     m_count_reg;
    logic                  m_done_reg;

    // Working values after a start flag has been applied.
    logic [LIMIT_BITS-1:0] eff_budget;
    logic [LIMIT_BITS-1:0] eff_chars;
    logic [LIMIT_BITS-1:0] chars_inc;
    logic [LIMIT_BITS-1:0] len_ext;
    logic [2:0]            eff_left;
    logic [CpW-1:0]        eff_acc;
    logic [CpW-1:0]        acc_shift;
    logic [CpW-1:0]        dlv_cp;
    logic                  eff_stopped;
    logic                  char_finite;
    logic                  budget_finite;
    logic                  do_finish;
    logic                  do_deliver;
    logic [1:0]            fin_status;
    logic                  produce;
    logic [CpW-1:0]        out_cp;
    logic [1:0]            out_status;
    logic [LIMIT_BITS-1:0] out_chars;
    logic                  out_done;

    assign pop = q_not_empty && (!m_valid_reg || m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_limit_reg <= '1;
            char_limit_reg <= '1;
        end else if (cfg_wen) begin
            if (cfg_index == u8d_pkg::REG_BYTE_LIMIT) begin
                byte_limit_reg <= cfg_wdata;
            end else begin
                char_limit_reg <= cfg_wdata;
            end
        end
    end

    always_comb begin
        eff_budget    = q_item.start ? byte_limit_reg : budget_reg;
        eff_chars     = q_item.start ? '0 : chars_reg;
        eff_left      = q_item.start ? 3'd0 : bytes_left_reg;
        eff_acc       = q_item.start ? '0 : acc_reg;
        eff_stopped   = q_item.start ? 1'b0 : stopped_reg;
        char_finite   = !(&char_limit_reg);
        budget_finite = !(&eff_budget);
        len_ext       = LIMIT_BITS'(q_item.seq_len);
        acc_shift     = {eff_acc[CpW-7:0], q_item.cont_bits};
        chars_inc     = (&eff_chars) ? eff_chars : eff_chars + 1'b1;

        bytes_left_next = bytes_left_reg;
        acc_next        = acc_reg;
        budget_next     = budget_reg;
        chars_next      = chars_reg;
        stopped_next    = stopped_reg;
        do_finish       = 1'b0;
        do_deliver      = 1'b0;
        fin_status      = u8d_pkg::ST_ILLEGAL;
        dlv_cp          = acc_shift;

        if (pop) begin
            bytes_left_next = eff_left;
            acc_next        = eff_acc;
            budget_next     = eff_budget;
            chars_next      = eff_chars;
            stopped_next    = eff_stopped;
            if (!eff_stopped) begin
                if (eff_left != 3'd0) begin
                    if (!q_item.is_cont) begin
                        do_finish  = 1'b1;
                        fin_status = u8d_pkg::ST_ILLEGAL;
                    end else begin
                        acc_next        = acc_shift;
                        bytes_left_next = eff_left - 3'd1;
                        do_deliver      = (eff_left == 3'd1);
                    end
                end else if (char_finite && (eff_chars >= char_limit_reg)) begin
                    do_finish  = 1'b1;
                    fin_status = u8d_pkg::ST_INCOMPLETE;
                end else if (q_item.bad_lead) begin
                    do_finish  = 1'b1;
                    fin_status = u8d_pkg::ST_ILLEGAL;
                end else if (budget_finite && (len_ext > eff_budget)) begin
                    do_finish  = 1'b1;
                    fin_status = u8d_pkg::ST_INCOMPLETE;
                end else begin
                    if (budget_finite) begin
                        budget_next = eff_budget - len_ext;
                    end
                    acc_next        = CpW'(q_item.lead_bits);
                    bytes_left_next = q_item.seq_len - 3'd1;
                    dlv_cp          = CpW'(q_item.lead_bits);
                    do_deliver      = (q_item.seq_len == 3'd1);
                end
            end
        end

        // A finished sequence that decodes to zero ends the string like NUL.
        if (do_deliver && (dlv_cp == '0)) begin
            do_deliver = 1'b0;
            do_finish  = 1'b1;
            fin_status = u8d_pkg::ST_NUL;
        end

        produce    = do_finish || do_deliver;
        out_cp     = '0;
        out_status = fin_status;
        out_chars  = eff_chars;
        out_done   = 1'b1;

        if (do_finish) begin
            stopped_next    = 1'b1;
            bytes_left_next = 3'd0;
            acc_next        = '0;
        end else if (do_deliver) begin
            bytes_left_next = 3'd0;
            acc_next        = '0;
            chars_next      = chars_inc;
            out_done        = char_finite && (chars_inc >= char_limit_reg);
            stopped_next    = out_done;
            out_cp          = dlv_cp;
            out_status      = u8d_pkg::ST_CHAR;
            out_chars       = chars_inc;
        end

        if (produce) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            budget_reg     <= '1;
            chars_reg      <= '0;
            bytes_left_reg <= 3'd0;
            acc_reg        <= '0;
            stopped_reg    <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            budget_reg     <= budget_next;
            chars_reg      <= chars_next;
            bytes_left_reg <= bytes_left_next;
            acc_reg        <= acc_next;
            stopped_reg    <= stopped_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (produce) begin
            m_cp_reg     <= out_cp;
            m_status_reg <= out_status;
            m_count_reg  <= CountW'(out_chars);
            m_done_reg   <= out_done;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {3'b000, m_count_reg, m_cp_reg};
    assign m_tuser  = m_status_reg;
    assign m_tlast  = m_done_reg;

`ifndef NO_ASSERTIONS
    // Every status other than a plain character ends the conversion.
    a_stop_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && (m_status_reg != u8d_pkg::ST_CHAR) |-> m_done_reg)
        else $error("non-character result without end flag");

    // A character result never carries the value zero.
    a_char_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && (m_status_reg == u8d_pkg::ST_CHAR) |-> (m_cp_reg != '0))
        else $error("character result with zero code point");

    // Once a conversion ends the decoder is stopped.
    a_end_stops: assert property (@(posedge aclk) disable iff (!aresetn)
        produce && out_done |=> stopped_reg)
        else $error("decoder not stopped after a final item");

    // A stopped decoder holds no sequence in progress.
    a_stop_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        stopped_reg |-> (bytes_left_reg == 3'd0) && (acc_reg == '0))
        else $error("sequence state left over while stopped");

    // An item is only taken from the queue when the output slot can hold it.
    a_pop_room: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> q_not_empty && (!m_valid_reg || m_tready))
        else $error("queue read without room at the output");
`endif

endmodule

/* tb/sv/testbench.sv */
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CP_W = u8d_pkg::CP_W;
    localparam int COUNT_W = u8d_pkg::COUNT_W;

    localparam int LIMIT_BITS = 16;
    localparam logic [LIMIT_BITS-1:0] UNLIMITED = '1;
    localparam int LATENCY = 8;
    localparam int RANDOM_ITEMS = 500;
    localparam int PHASE_ITEMS = 60;

    typedef struct packed {
        logic [CP_W-1:0]    cp;
        logic [1:0]         status;
        logic [COUNT_W-1:0] count;
        logic               done;
    } utf8_result_t;

    // Tracks the decoder state and holds the results that accepted bytes must produce.
    class utf8_scoreboard;
        logic [LIMIT_BITS-1:0] byte_lim;
        logic [LIMIT_BITS-1:0] char_lim;
        logic [2:0]            cont_left;
        logic [CP_W-1:0]       cp_acc;
        logic [LIMIT_BITS-1:0] budget;
        logic [LIMIT_BITS-1:0] chars;
        bit                    halted;
        utf8_result_t          expected_q[$];
        int                    errors;

        function new();
            byte_lim = UNLIMITED;
            char_lim = UNLIMITED;
            errors = 0;
            restart();
        endfunction

        function void restart();
            cont_left = '0;
            cp_acc = '0;
            budget = byte_lim;
            chars = '0;
            halted = 1'b0;
        endfunction

        function void load_limit(logic index, logic [LIMIT_BITS-1:0] value);
            if (index == u8d_pkg::REG_BYTE_LIMIT)
                byte_lim = value;
            else
                char_lim = value;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void stop_with(logic [1:0] status);
            utf8_result_t r;
            halted = 1'b1;
            cont_left = '0;
            cp_acc = '0;
            r.cp = '0;
            r.status = status;
            r.count = chars;
            r.done = 1'b1;
            expected_q.push_back(r);
        endfunction

        // A decoded value of zero, overlong or not, ends the string like NUL.
        function void emit_char();
            utf8_result_t r;
            if (cp_acc == '0) begin
                stop_with(u8d_pkg::ST_NUL);
                return;
            end
            r.cp = cp_acc;
            cont_left = '0;
            cp_acc = '0;
            if (chars != UNLIMITED)
                chars++;
            r.done = (char_lim != UNLIMITED) && (chars >= char_lim);
            if (r.done)
                halted = 1'b1;
            r.status = u8d_pkg::ST_CHAR;
            r.count = chars;
            expected_q.push_back(r);
        endfunction

        function void note_byte(logic [7:0] value, logic first);
            int ones;
            int seq_len;
            if (first)
                restart();
            if (halted)
                return;
            if (cont_left != 0) begin
                if (value[7:6] != 2'b10) begin
                    stop_with(u8d_pkg::ST_ILLEGAL);
                    return;
                end
                cp_acc = {cp_acc[CP_W-7:0], value[5:0]};
                cont_left--;
                if (cont_left == 0)
                    emit_char();
                return;
            end
            if (char_lim != UNLIMITED && chars >= char_lim) begin
                stop_with(u8d_pkg::ST_INCOMPLETE);
                return;
            end
            ones = 0;
            while (ones < 8 && value[7-ones])
                ones++;
            if (ones == 1 || ones > 4) begin
                stop_with(u8d_pkg::ST_ILLEGAL);
                return;
            end
            seq_len = (ones == 0) ? 1 : ones;
            // The whole sequence length is charged against the budget at the lead byte.
            if (budget != UNLIMITED) begin
                if (seq_len > budget) begin
                    stop_with(u8d_pkg::ST_INCOMPLETE);
                    return;
                end
                budget -= seq_len;
            end
            if (ones == 0) begin
                cp_acc = CP_W'(value);
                emit_char();
                return;
            end
            cp_acc = CP_W'(value & (8'hFF >> (ones + 1)));
            cont_left = 3'(ones - 1);
        endfunction

        task report(string what);
            $display("%0t ns: mismatch: %s", $time, what);
            errors++;
        endtask

        task check_result(logic [CP_W-1:0] cp, logic [1:0] status,
                          logic [COUNT_W-1:0] count, logic done);
            utf8_result_t e;
            if (expected_q.size() == 0) begin
                report($sformatf("unexpected result cp=%h status=%0d count=%0d done=%b",
                                 cp, status, count, done));
                return;
            end
            e = expected_q.pop_front();
            if (cp !== e.cp)
                report($sformatf("code point %h, expected %h", cp, e.cp));
            if (status !== e.status)
                report($sformatf("status %0d, expected %0d", status, e.status));
            if (count !== e.count)
                report($sformatf("char count %0d, expected %0d", count, e.count));
            if (done !== e.done)
                report($sformatf("done flag %b, expected %b", done, e.done));
        endtask
    endclass

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_wen = 1'b0;
    logic                  cfg_index = u8d_pkg::REG_BYTE_LIMIT;
    logic [LIMIT_BITS-1:0] cfg_wdata = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [7:0]            s_tdata = '0;
    logic                  s_tuser = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [39:0]           m_tdata;
    logic [1:0]            m_tuser;
    logic                  m_tlast;

    utf8_scoreboard sb = new();
    bit tx_gaps_on = 1'b0;
    bit rx_stalls_on = 1'b0;
    int items_sent = 0;
    int rx_wait = 0;

    utf8_decode_stream #(.LIMIT_BITS(LIMIT_BITS)) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap(bit enabled);
        int r;
        if (!enabled)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    always @(posedge aclk) begin
        if (rx_wait == 0) begin
            m_tready <= 1'b1;
            rx_wait = pick_gap(rx_stalls_on);
        end else begin
            m_tready <= 1'b0;
            rx_wait--;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(m_tdata[20:0], m_tuser, m_tdata[36:21], m_tlast);
    end

    task automatic send_byte(input logic [7:0] value, input logic first);
        int gap;
        gap = pick_gap(tx_gaps_on);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            s_tdata  <= 8'($urandom);
            s_tuser  <= 1'($urandom);
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        s_tuser  <= first;
        do @(posedge aclk); while (!s_tready);
        sb.note_byte(value, first);
        items_sent++;
    endtask

    // Holds the input back until every outstanding result has come out.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge aclk);
        repeat (LATENCY) @(posedge aclk);
    endtask

    task automatic write_limits(input logic [LIMIT_BITS-1:0] byte_lim,
                                input logic [LIMIT_BITS-1:0] char_lim);
        cfg_wen   <= 1'b1;
        cfg_index <= u8d_pkg::REG_BYTE_LIMIT;
        cfg_wdata <= byte_lim;
        @(posedge aclk);
        sb.load_limit(u8d_pkg::REG_BYTE_LIMIT, byte_lim);
        cfg_index <= u8d_pkg::REG_CHAR_LIMIT;
        cfg_wdata <= char_lim;
        @(posedge aclk);
        sb.load_limit(u8d_pkg::REG_CHAR_LIMIT, char_lim);
        cfg_wen <= 1'b0;
    endtask

    task automatic send_char(input logic first);
        int kind;
        int n;
        logic [7:0] lead;
        kind = $urandom_range(0, 99);
        n = 1;
        if (kind < 40) begin
            lead = {1'b0, 7'($urandom_range(1, 127))};
        end else if (kind < 60) begin
            n = 2;
            lead = {3'b110, 5'($urandom)};
        end else if (kind < 78) begin
            n = 3;
            lead = {4'b1110, 4'($urandom)};
        end else if (kind < 90) begin
            n = 4;
            lead = {5'b11110, 3'($urandom)};
        end else if (kind < 95) begin
            send_byte(8'($urandom), first);
            return;
        end else begin
            // A three-byte sequence cut short by a byte that is not a continuation.
            send_byte({4'b1110, 4'($urandom)}, first);
            send_byte({2'b10, 6'($urandom)}, 1'b0);
            if ($urandom_range(0, 1))
                send_byte({1'b0, 7'($urandom)}, 1'b0);
            else
                send_byte({2'b11, 6'($urandom)}, 1'b0);
            return;
        end
        send_byte(lead, first);
        for (int i = 1; i < n; i++)
            send_byte({2'b10, 6'($urandom)}, 1'b0);
    endtask

    task automatic send_string();
        int nchars;
        nchars = $urandom_range(1, 8);
        send_char($urandom_range(0, 9) != 0);
        for (int i = 1; i < nchars; i++)
            send_char(1'b0);
        if ($urandom_range(0, 4) == 0)
            send_byte(8'h00, 1'b0);
    endtask

    function automatic logic [LIMIT_BITS-1:0] pick_limit();
        int r;
        r = $urandom_range(0, 99);
        if (r < 15)
            return UNLIMITED;
        if (r < 20)
            return '0;
        if (r < 80)
            return LIMIT_BITS'($urandom_range(1, 24));
        return LIMIT_BITS'($urandom);
    endfunction

    initial begin
        logic [LIMIT_BITS-1:0] byte_table[8];
        logic [LIMIT_BITS-1:0] char_table[8];
        int phase;
        int phase_end;

        byte_table = '{UNLIMITED, 16'd0, 16'd6, UNLIMITED, 16'd20, 16'd1, 16'd65534, 16'd12};
        char_table = '{UNLIMITED, UNLIMITED, 16'd3, 16'd0, 16'd5, 16'd2, 16'd65534, 16'd1};

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        write_limits(UNLIMITED, UNLIMITED);

        // Extremes, every sequence length and the error cases with no limits in force.
        send_byte(8'h41, 1'b1);
        send_byte(8'h7F, 1'b0);
        send_byte(8'hC3, 1'b0);
        send_byte(8'hA9, 1'b0);
        send_byte(8'hE2, 1'b0);
        send_byte(8'h82, 1'b0);
        send_byte(8'hAC, 1'b0);
        send_byte(8'hF4, 1'b0);
        send_byte(8'h8F, 1'b0);
        send_byte(8'hBF, 1'b0);
        send_byte(8'hBF, 1'b0);
        send_byte(8'hF7, 1'b0);
        send_byte(8'hBF, 1'b0);
        send_byte(8'hBF, 1'b0);
        send_byte(8'hBF, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h55, 1'b0);
        send_byte(8'hFF, 1'b1);
        send_byte(8'hF8, 1'b1);
        send_byte(8'hC3, 1'b1);
        send_byte(8'h41, 1'b0);
        send_byte(8'hC0, 1'b1);
        send_byte(8'h80, 1'b0);
        send_byte(8'h00, 1'b1);
        send_byte(8'h41, 1'b1);
        send_byte(8'h42, 1'b0);
        drain();

        // Character limit lowered below the count in the middle of a string.
        write_limits(UNLIMITED, 16'd1);
        send_byte(8'h44, 1'b0);
        drain();

        // A sequence that overruns the byte budget, then a character limit that is reached.
        write_limits(16'd3, 16'd2);
        send_byte(8'hE2, 1'b1);
        send_byte(8'h82, 1'b0);
        send_byte(8'hAC, 1'b0);
        send_byte(8'h41, 1'b0);
        send_byte(8'h41, 1'b1);
        send_byte(8'h42, 1'b0);
        drain();
        write_limits(UNLIMITED, 16'd0);
        send_byte(8'h41, 1'b1);
        drain();

        items_sent = 0;
        phase = 0;
        while (items_sent < RANDOM_ITEMS) begin
            if (phase < 8) begin
                write_limits(byte_table[phase], char_table[phase]);
            end else begin
                write_limits(pick_limit(), pick_limit());
            end
            tx_gaps_on = (phase != 0) && ($urandom_range(0, 4) != 0);
            rx_stalls_on = (phase != 0) && ($urandom_range(0, 4) != 0);
            phase_end = items_sent + PHASE_ITEMS;
            while (items_sent < phase_end && items_sent < RANDOM_ITEMS)
                send_string();
            drain();
            phase++;
        end

        repeat (LATENCY) @(posedge aclk);
        if (sb.errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("timeout with %0d results outstanding", sb.pending());
        $display("*** FAILED ***");
        $finish;
    end

endmodule

/* files.f */
sv/u8d_pkg.sv
sv/u8d_front.sv
sv/u8d_queue.sv
sv/u8d_back.sv
sv/utf8_decode_stream.sv
tb/sv/testbench.sv
